// ===== rtl/mcg_pkg.sv =====
// mcg_pkg: shared widths, constants, lookup tables and types for the month calendar grid
`timescale 1ns / 1ps

package mcg_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int ROW_W   = 3;
  localparam int COL_W   = 3;
  localparam int YY_W    = 15;  // year plus one 400-year cycle
  localparam int W_W     = 15;  // weekday sum before mod 7
  localparam int CELL_W  = 6;   // cell index 0..41

  localparam logic [COL_W-1:0] NO_COLUMN = 3'd7;
  localparam logic [2:0]       SUNDAY_IDX = 3'd6;   // Sunday in Monday-first order

  // reciprocal for divide by 100: q = (x * RECIP_100) >> SHIFT_100, exact for x < 43690
  localparam logic [15:0] RECIP_100 = 16'd41944;
  localparam int          SHIFT_100 = 22;
  // reciprocal for divide by 7: q = (x * RECIP_7) >> SHIFT_7, exact for x < 43690
  localparam logic [15:0] RECIP_7   = 16'd37450;
  localparam int          SHIFT_7   = 18;

  localparam logic [YY_W-1:0] CYCLE_400 = 15'd400;

  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;

  // grid info for one month, handed from the date pipe to the row emitter
  typedef struct packed {
    logic [2:0]       start;   // Monday-first column of the 1st
    logic [DAY_W-1:0] ndays;
    logic [ROW_W-1:0] weeks;
    logic [DAY_W-1:0] hl_day;
    logic             bad;
  } mcg_grid_t;

  // weekday table offset, month 1..12
  function automatic logic [2:0] sak_offset(input logic [MONTH_W-1:0] m);
    logic [2:0] r;
    begin
      case (m)
        4'd1:    r = 3'd0;
        4'd2:    r = 3'd3;
        4'd3:    r = 3'd2;
        4'd4:    r = 3'd5;
        4'd5:    r = 3'd0;
        4'd6:    r = 3'd3;
        4'd7:    r = 3'd5;
        4'd8:    r = 3'd1;
        4'd9:    r = 3'd4;
        4'd10:   r = 3'd6;
        4'd11:   r = 3'd2;
        4'd12:   r = 3'd4;
        default: r = 3'd0;
      endcase
      return r;
    end
  endfunction

  // month length in a common year
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] r;
    begin
      case (m)
        4'd2:                     r = 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11:  r = 5'd30;
        default:                  r = 5'd31;
      endcase
      return r;
    end
  endfunction

endpackage

// ===== rtl/mcg_if.sv =====
// mcg_in_if, mcg_out_if: request and week row channels
`timescale 1ns / 1ps

interface mcg_in_if import mcg_pkg::*;;
  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0] month;
  logic [DAY_W-1:0]   highlight_day;

  modport source (output valid, output year, output month, output highlight_day,
                  input ready);
  modport sink   (input valid, input year, input month, input highlight_day,
                  output ready);
endinterface

interface mcg_out_if import mcg_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] week_row;
  logic [DAY_W-1:0] day_monday;
  logic [DAY_W-1:0] day_tuesday;
  logic [DAY_W-1:0] day_wednesday;
  logic [DAY_W-1:0] day_thursday;
  logic [DAY_W-1:0] day_friday;
  logic [DAY_W-1:0] day_saturday;
  logic [DAY_W-1:0] day_sunday;
  logic [COL_W-1:0] highlight_column;
  logic             bad_month;
  logic             last_row;

  modport source (output valid, output week_row, output day_monday, output day_tuesday,
                  output day_wednesday, output day_thursday, output day_friday,
                  output day_saturday, output day_sunday, output highlight_column,
                  output bad_month, output last_row, input ready);
  modport sink   (input valid, input week_row, input day_monday, input day_tuesday,
                  input day_wednesday, input day_thursday, input day_friday,
                  input day_saturday, input day_sunday, input highlight_column,
                  input bad_month, input last_row, output ready);
endinterface

// ===== rtl/month_calendar_grid_top.sv =====
// month_calendar_grid_top: Monday-first month calendar as a stream of week rows
// path: a request passes five date stages, the emitter state and the output register
// throughput: one week row per cycle unless out_ch.ready is low; a month is 4 to 6 rows
//   (1 if invalid); the five-stage date pipe takes a request each cycle when not stalled
// reset: synchronous active-low rst_n empties every stage and the output register
`timescale 1ns / 1ps

module month_calendar_grid_top import mcg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  mcg_in_if.sink      in_ch,
  mcg_out_if.source   out_ch
);

  logic       grid_valid;
  logic       grid_ready;
  mcg_grid_t  grid;
  logic [DAY_W-1:0] days [7];

  // date arithmetic pipe
  mcg_date u_date (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_ch.valid),
    .up_ready (in_ch.ready),
    .up_year  (in_ch.year),
    .up_month (in_ch.month),
    .up_hl    (in_ch.highlight_day),
    .dn_valid (grid_valid),
    .dn_ready (grid_ready),
    .dn_grid  (grid)
  );

  // row emitter
  mcg_rows u_rows (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_valid     (grid_valid),
    .up_ready     (grid_ready),
    .up_grid      (grid),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_week_row (out_ch.week_row),
    .out_days     (days),
    .out_hl_col   (out_ch.highlight_column),
    .out_bad      (out_ch.bad_month),
    .out_last     (out_ch.last_row)
  );

  assign out_ch.day_monday    = days[0];
  assign out_ch.day_tuesday   = days[1];
  assign out_ch.day_wednesday = days[2];
  assign out_ch.day_thursday  = days[3];
  assign out_ch.day_friday    = days[4];
  assign out_ch.day_saturday  = days[5];
  assign out_ch.day_sunday    = days[6];

endmodule

// ===== rtl/mcg_date.sv =====
// mcg_date: five-stage pipe from year and month to first weekday, month length and row count
`timescale 1ns / 1ps

module mcg_date import mcg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  logic [YEAR_W-1:0]  up_year,
  input  logic [MONTH_W-1:0] up_month,
  input  logic [DAY_W-1:0]   up_hl,
  output logic               dn_valid,
  input  logic               dn_ready,
  output mcg_grid_t          dn_grid
);

  // stage valid bits
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic can1, can2, can3, can4, can5;

  // stage 1 payload
  logic [YY_W-1:0]   s1_yy_r;
  logic [YEAR_W-1:0] s1_year_r;
  logic [2:0]        s1_off_r;
  logic [DAY_W-1:0]  s1_len_r;
  logic              s1_feb_r;
  logic [DAY_W-1:0]  s1_hl_r;
  logic              s1_bad_r;

  // stage 2 payload
  logic [YY_W-1:0]   s2_yy_r;
  logic [YEAR_W-1:0] s2_year_r;
  logic [7:0]        s2_qyy_r;
  logic [7:0]        s2_qyear_r;
  logic [2:0]        s2_off_r;
  logic [DAY_W-1:0]  s2_len_r;
  logic              s2_feb_r;
  logic [DAY_W-1:0]  s2_hl_r;
  logic              s2_bad_r;

  // stage 3 payload
  logic [W_W-1:0]    s3_w_r;
  logic [DAY_W-1:0]  s3_ndays_r;
  logic [DAY_W-1:0]  s3_hl_r;
  logic              s3_bad_r;

  // stage 4 payload
  logic [W_W-1:0]    s4_w_r;
  logic [11:0]       s4_q7_r;
  logic [DAY_W-1:0]  s4_ndays_r;
  logic [DAY_W-1:0]  s4_hl_r;
  logic              s4_bad_r;

  // stage 5 payload
  mcg_grid_t         s5_grid_r;

  // combinational values per stage
  logic [YY_W-1:0]   s1_yy_nxt;
  logic              s1_bad_nxt;
  logic [30:0]       prod_yy;
  logic [29:0]       prod_year;
  logic [5:0]        q400;
  logic [YEAR_W-1:0] rem100;
  logic              leap;
  logic [W_W-1:0]    s3_w_nxt;
  logic [DAY_W-1:0]  s3_ndays_nxt;
  logic [30:0]       prod_w;
  logic [W_W-1:0]    mod7_full;
  logic [2:0]        mod7;
  logic [2:0]        start;
  logic [CELL_W-1:0] span;
  mcg_grid_t         s5_grid_nxt;

  // handshake chain: a stage loads when it is empty or moving on
  assign can5     = !v5_r || dn_ready;
  assign can4     = !v4_r || (v4_r && can5);
  assign can3     = !v3_r || (v3_r && can4);
  assign can2     = !v2_r || (v2_r && can3);
  assign can1     = !v1_r || (v1_r && can2);
  assign up_ready = can1;
  assign dn_valid = v5_r;
  assign dn_grid  = s5_grid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (can1) v1_r <= up_valid;
      if (can2) v2_r <= v1_r;
      if (can3) v3_r <= v2_r;
      if (can4) v4_r <= v3_r;
      if (can5) v5_r <= v4_r;
    end
  end

  // stage 1: shifted year for the Jan/Feb borrow, month tables
  always_comb begin
    s1_bad_nxt = !(up_month inside {[4'd1:4'd12]});
    s1_yy_nxt  = {1'b0, up_year} + CYCLE_400 - ((up_month < MONTH_MAR) ? 15'd1 : 15'd0);
  end

  always_ff @(posedge clk) begin
    if (can1) begin
      s1_yy_r   <= s1_yy_nxt;
      s1_year_r <= up_year;
      s1_off_r  <= sak_offset(up_month);
      s1_len_r  <= month_len(up_month);
      s1_feb_r  <= (up_month == MONTH_FEB);
      s1_hl_r   <= up_hl;
      s1_bad_r  <= s1_bad_nxt;
    end
  end

  // stage 2: divide by 100 through reciprocal multiply
  always_comb begin
    prod_yy   = s1_yy_r * RECIP_100;
    prod_year = s1_year_r * RECIP_100;
  end

  always_ff @(posedge clk) begin
    if (can2) begin
      s2_yy_r    <= s1_yy_r;
      s2_year_r  <= s1_year_r;
      s2_qyy_r   <= prod_yy[SHIFT_100 +: 8];
      s2_qyear_r <= prod_year[SHIFT_100 +: 8];
      s2_off_r   <= s1_off_r;
      s2_len_r   <= s1_len_r;
      s2_feb_r   <= s1_feb_r;
      s2_hl_r    <= s1_hl_r;
      s2_bad_r   <= s1_bad_r;
    end
  end

  // stage 3: leap test and weekday sum
  always_comb begin
    q400   = s2_qyy_r[7:2];
    rem100 = s2_year_r - ({s2_qyear_r, 6'b0} + {1'b0, s2_qyear_r, 5'b0}
                          + {4'b0, s2_qyear_r, 2'b0});
    leap   = (s2_year_r[1:0] == 2'b00) && ((rem100 != '0) || (s2_qyear_r[1:0] == 2'b00));
    s3_w_nxt = s2_yy_r + {2'b0, s2_yy_r[YY_W-1:2]} - {7'b0, s2_qyy_r} + {9'b0, q400}
               + {12'b0, s2_off_r} + 15'd1;
    s3_ndays_nxt = s2_len_r + ((s2_feb_r && leap) ? 5'd1 : 5'd0);
  end

  always_ff @(posedge clk) begin
    if (can3) begin
      s3_w_r     <= s3_w_nxt;
      s3_ndays_r <= s3_ndays_nxt;
      s3_hl_r    <= s2_hl_r;
      s3_bad_r   <= s2_bad_r;
    end
  end

  // stage 4: divide weekday sum by 7
  assign prod_w = s3_w_r * RECIP_7;

  always_ff @(posedge clk) begin
    if (can4) begin
      s4_w_r     <= s3_w_r;
      s4_q7_r    <= prod_w[SHIFT_7 +: 12];
      s4_ndays_r <= s3_ndays_r;
      s4_hl_r    <= s3_hl_r;
      s4_bad_r   <= s3_bad_r;
    end
  end

  // stage 5: remainder, Monday-first start column, row count
  always_comb begin
    mod7_full = s4_w_r - ({s4_q7_r, 3'b0} - {3'b0, s4_q7_r});
    mod7      = mod7_full[2:0];
    start     = (mod7 == 3'd0) ? SUNDAY_IDX : (mod7 - 3'd1);
    span      = {3'b0, start} + {1'b0, s4_ndays_r};
    s5_grid_nxt.start  = start;
    s5_grid_nxt.ndays  = s4_ndays_r;
    s5_grid_nxt.hl_day = s4_hl_r;
    s5_grid_nxt.bad    = s4_bad_r;
    if (s4_bad_r)              s5_grid_nxt.weeks = 3'd1;
    else if (span <= 6'd28)    s5_grid_nxt.weeks = 3'd4;
    else if (span <= 6'd35)    s5_grid_nxt.weeks = 3'd5;
    else                       s5_grid_nxt.weeks = 3'd6;
  end

  always_ff @(posedge clk) begin
    if (can5) begin
      s5_grid_r <= s5_grid_nxt;
    end
  end

endmodule

// ===== rtl/mcg_rows.sv =====
// mcg_rows: walks one month grid row by row into a registered output beat
`timescale 1ns / 1ps

module mcg_rows import mcg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  mcg_grid_t        up_grid,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ROW_W-1:0] out_week_row,
  output logic [DAY_W-1:0] out_days [7],
  output logic [COL_W-1:0] out_hl_col,
  output logic             out_bad,
  output logic             out_last
);

  logic             em_v_r;
  mcg_grid_t        em_grid_r;
  logic [ROW_W-1:0] row_r;

  logic             out_v_r;
  logic [ROW_W-1:0] week_row_r;
  logic [DAY_W-1:0] days_r [7];
  logic [COL_W-1:0] hl_col_r;
  logic             bad_r;
  logic             last_r;

  logic             out_load;
  logic             is_last;
  logic             em_can;
  logic [CELL_W-1:0] base;
  logic [CELL_W-1:0] cell_idx;
  logic [CELL_W-1:0] stop;
  logic [CELL_W-1:0] day_full;
  logic [DAY_W-1:0] days_nxt [7];
  logic [COL_W-1:0] hl_col_nxt;

  assign out_load = em_v_r && (!out_v_r || out_ready);
  assign is_last  = (row_r == em_grid_r.weeks - 3'd1);
  assign em_can   = !em_v_r || (out_load && is_last);
  assign up_ready = em_can;

  // emitter state: current grid and row index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (em_can) em_v_r <= up_valid;
      if (out_load)       out_v_r <= 1'b1;
      else if (out_ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (em_can && up_valid) begin
      em_grid_r <= up_grid;
      row_r     <= '0;
    end else if (out_load) begin
      row_r     <= row_r + 3'd1;
    end
  end

  // day numbers of the current row and the highlight column
  always_comb begin
    base       = {row_r, 3'b0} - {3'b0, row_r};
    stop       = {3'b0, em_grid_r.start} + {1'b0, em_grid_r.ndays};
    hl_col_nxt = NO_COLUMN;
    cell_idx   = '0;
    day_full   = '0;
    for (int c = 0; c < 7; c++) begin
      cell_idx = base + CELL_W'(c);
      day_full = cell_idx - {3'b0, em_grid_r.start} + 6'd1;
      if (!em_grid_r.bad && (cell_idx >= {3'b0, em_grid_r.start}) && (cell_idx < stop)) begin
        days_nxt[c] = day_full[DAY_W-1:0];
      end else begin
        days_nxt[c] = '0;
      end
      if ((days_nxt[c] != '0) && (days_nxt[c] == em_grid_r.hl_day)) begin
        hl_col_nxt = COL_W'(c);
      end
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (out_load) begin
      week_row_r <= row_r;
      days_r     <= days_nxt;
      hl_col_r   <= hl_col_nxt;
      bad_r      <= em_grid_r.bad;
      last_r     <= is_last;
    end
  end

  assign out_valid    = out_v_r;
  assign out_week_row = week_row_r;
  assign out_days     = days_r;
  assign out_hl_col   = hl_col_r;
  assign out_bad      = bad_r;
  assign out_last     = last_r;

endmodule

// ===== rtl/mcg_checker.sv =====
// mcg_checker: port-level checks on the week row stream, bound to the top level
`timescale 1ns / 1ps

module mcg_checker import mcg_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [ROW_W-1:0] out_week_row,
  input logic [DAY_W-1:0] out_day_monday,
  input logic [DAY_W-1:0] out_day_sunday,
  input logic [COL_W-1:0] out_highlight_column,
  input logic             out_bad_month,
  input logic             out_last_row
);

  // a stalled beat holds its contents
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_week_row)
      && $stable(out_last_row) && $stable(out_day_monday))
    else $error("week row beat changed while stalled");

  // rows of one month come back to back with rising index
  a_next_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_row |=>
      out_valid && (out_week_row == $past(out_week_row) + 3'd1))
    else $error("week row sequence broken");

  // an invalid month is one blank row
  a_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_month |-> out_last_row && (out_week_row == '0)
      && (out_highlight_column == NO_COLUMN) && (out_day_monday == '0)
      && (out_day_sunday == '0))
    else $error("invalid month beat malformed");

  // a valid month ends on row 3, 4 or 5
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_row && !out_bad_month |->
      (out_week_row == 3'd3) || (out_week_row == 3'd4) || (out_week_row == 3'd5))
    else $error("month grid has wrong row count");

endmodule

bind month_calendar_grid_top mcg_checker u_mcg_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .out_week_row         (out_ch.week_row),
  .out_day_monday       (out_ch.day_monday),
  .out_day_sunday       (out_ch.day_sunday),
  .out_highlight_column (out_ch.highlight_column),
  .out_bad_month        (out_ch.bad_month),
  .out_last_row         (out_ch.last_row)
);
